/* design/spq_pkg.sv */
package spq_pkg;

    // queue geometry
    localparam int DEPTH = 8;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int PRI_W = 8;
    localparam int OCC_W = 4;

    // operation kinds
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // result status codes
    localparam logic [1:0] ST_ENQ   = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_DEQ   = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // operation broadcast to every cell of the chain
    typedef struct packed {
        logic                    enq;
        logic                    deq;
        logic signed [VAL_W-1:0] value;
        logic [PRI_W-1:0]        prio;
    } op_t;

    // position of a cell relative to the current fill level
    typedef struct packed {
        logic occupied;
        logic at_tail;
    } pos_t;

endpackage

/* design/spq_cell.sv */
module spq_cell (
    input  logic                                  aclk,
    input  spq_pkg::op_t                          op,
    input  spq_pkg::pos_t                         pos,
    input  logic                                  left_gt,
    input  logic signed [spq_pkg::VAL_W-1:0]      left_value,
    input  logic [spq_pkg::PRI_W-1:0]             left_prio,
    input  logic signed [spq_pkg::VAL_W-1:0]      right_value,
    input  logic [spq_pkg::PRI_W-1:0]             right_prio,
    output logic                                  gt,
    output logic signed [spq_pkg::VAL_W-1:0]      value,
    output logic [spq_pkg::PRI_W-1:0]             prio
);

    logic signed [spq_pkg::VAL_W-1:0] value_reg;
    logic signed [spq_pkg::VAL_W-1:0] value_next;
    logic [spq_pkg::PRI_W-1:0]        prio_reg;
    logic [spq_pkg::PRI_W-1:0]        prio_next;

    // new entry goes in front of this one
    assign gt    = op.prio < prio_reg;
    assign value = value_reg;
    assign prio  = prio_reg;

    // pick keep, shift from left, take new, or shift from right
    always_comb begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (op.enq) begin
            if ((pos.occupied && gt) || pos.at_tail) begin
                if (left_gt) begin
                    value_next = left_value;
                    prio_next  = left_prio;
                end else begin
                    value_next = op.value;
                    prio_next  = op.prio;
                end
            end
        end else if (op.deq && pos.occupied) begin
            value_next = right_value;
            prio_next  = right_prio;
        end
    end

    // payload storage, no reset needed
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

endmodule

/* design/sorted_priority_queue.sv */
// sorted priority queue as a chain of shift cells, lowest priority number at cell 0
// the result is registered on acceptance and presented in the following cycle
// throughput: one enqueue or dequeue per cycle while m_ready does not stall the result register
// a stalled result register holds off input only while m_ready stays low
// reset (aresetn, synchronous, active low) empties the queue and drops m_valid;
// cell contents are not cleared
module sorted_priority_queue (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_kind,
    input  logic signed [spq_pkg::VAL_W-1:0]      s_value,
    input  logic [spq_pkg::PRI_W-1:0]             s_priority_req,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_status,
    output logic signed [spq_pkg::VAL_W-1:0]      m_head_value,
    output logic [spq_pkg::OCC_W-1:0]             m_occupancy
);

    localparam int D = spq_pkg::DEPTH;

    logic                                 accept;
    logic                                 full;
    logic                                 empty;
    spq_pkg::op_t                         op;
    logic [spq_pkg::CNT_W-1:0]            count_reg;
    logic [spq_pkg::CNT_W-1:0]            count_next;
    logic                                 m_valid_reg;
    logic [1:0]                           status_reg;
    logic [1:0]                           status_next;
    logic signed [spq_pkg::VAL_W-1:0]     head_reg;
    logic signed [spq_pkg::VAL_W-1:0]     head_next;
    logic [spq_pkg::OCC_W-1:0]            occ_reg;

    logic [D-1:0]                         cell_gt;
    logic signed [spq_pkg::VAL_W-1:0]     cell_value [D];
    logic [spq_pkg::PRI_W-1:0]            cell_prio  [D];

    // handshake
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = count_reg == spq_pkg::CNT_W'(D);
    assign empty   = count_reg == '0;

    // operation broadcast to the chain
    always_comb begin
        op.enq   = accept && (s_kind == spq_pkg::KIND_ENQ) && !full;
        op.deq   = accept && (s_kind == spq_pkg::KIND_DEQ) && !empty;
        op.value = s_value;
        op.prio  = s_priority_req;
    end

    // chain of cells
    for (genvar i = 0; i < D; i++) begin : g_cell
        spq_pkg::pos_t                     pos;
        logic                              l_gt;
        logic signed [spq_pkg::VAL_W-1:0]  l_value;
        logic [spq_pkg::PRI_W-1:0]         l_prio;
        logic signed [spq_pkg::VAL_W-1:0]  r_value;
        logic [spq_pkg::PRI_W-1:0]         r_prio;

        assign pos.occupied = count_reg > spq_pkg::CNT_W'(i);
        assign pos.at_tail  = count_reg == spq_pkg::CNT_W'(i);

        if (i == 0) begin : g_head
            assign l_gt    = 1'b0;
            assign l_value = '0;
            assign l_prio  = '0;
        end else begin : g_mid
            assign l_gt    = cell_gt[i-1];
            assign l_value = cell_value[i-1];
            assign l_prio  = cell_prio[i-1];
        end

        if (i == D - 1) begin : g_tail
            assign r_value = '0;
            assign r_prio  = '0;
        end else begin : g_body
            assign r_value = cell_value[i+1];
            assign r_prio  = cell_prio[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .op          (op),
            .pos         (pos),
            .left_gt     (l_gt),
            .left_value  (l_value),
            .left_prio   (l_prio),
            .right_value (r_value),
            .right_prio  (r_prio),
            .gt          (cell_gt[i]),
            .value       (cell_value[i]),
            .prio        (cell_prio[i])
        );
    end

    // fill level and result
    always_comb begin
        count_next  = count_reg;
        status_next = spq_pkg::ST_ENQ;
        head_next   = '0;
        if (s_kind == spq_pkg::KIND_ENQ) begin
            if (full) begin
                status_next = spq_pkg::ST_FULL;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end else begin
            if (empty) begin
                status_next = spq_pkg::ST_EMPTY;
            end else begin
                status_next = spq_pkg::ST_DEQ;
                head_next   = cell_value[0];
                count_next  = count_reg - 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (s_ready) begin
                m_valid_reg <= s_valid;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            head_reg   <= head_next;
            occ_reg    <= spq_pkg::OCC_W'(count_next);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_head_value = head_reg;
    assign m_occupancy  = occ_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= spq_pkg::CNT_W'(D))
        else $error("fill level beyond depth");

    a_enq_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        op.enq |=> count_reg == $past(count_reg) + 1'b1)
        else $error("enqueue did not grow the queue");

    a_deq_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        op.deq |=> count_reg == $past(count_reg) - 1'b1)
        else $error("dequeue did not shrink the queue");

    a_zero_head: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != spq_pkg::ST_DEQ) |-> m_head_value == '0)
        else $error("head value set on a non-dequeue result");

    a_empty_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == spq_pkg::ST_EMPTY) |-> m_occupancy == '0)
        else $error("empty rejection with entries held");

endmodule

/* tb/spq_order_checker.sv */
`timescale 1ns / 1ps

// watches both channels, keeps its own sorted copy of the queue and checks each reply
module spq_order_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic                             s_kind,
    input  logic signed [spq_pkg::VAL_W-1:0] s_value,
    input  logic [spq_pkg::PRI_W-1:0]        s_priority_req,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [1:0]                       m_status,
    input  logic signed [spq_pkg::VAL_W-1:0] m_head_value,
    input  logic [spq_pkg::OCC_W-1:0]        m_occupancy,
    output int                               mismatch_count,
    output int                               replies_outstanding
);

    typedef struct packed {
        logic [1:0]                       status;
        logic signed [spq_pkg::VAL_W-1:0] head_value;
        logic [spq_pkg::OCC_W-1:0]        occupancy;
    } reply_t;

    // shadow queue contents, slot 0 is the head
    logic signed [spq_pkg::VAL_W-1:0] held_values [spq_pkg::DEPTH];
    logic [spq_pkg::PRI_W-1:0]        held_prios  [spq_pkg::DEPTH];
    int                               held;
    int                               faults;
    reply_t                           awaited_replies [$];

    // apply one operation to the shadow queue and form the reply it should give
    function automatic reply_t apply_queue_op(input logic kind,
                                              input logic signed [spq_pkg::VAL_W-1:0] v,
                                              input logic [spq_pkg::PRI_W-1:0] p);
        reply_t r;
        int     slot;
        r.status     = spq_pkg::ST_ENQ;
        r.head_value = '0;
        if (kind == spq_pkg::KIND_ENQ) begin
            if (held >= spq_pkg::DEPTH) begin
                r.status = spq_pkg::ST_FULL;
            end else begin
                slot = held;
                // entries with a strictly larger priority number move up one place
                while (slot > 0 && p < held_prios[slot-1]) begin
                    held_values[slot] = held_values[slot-1];
                    held_prios[slot]  = held_prios[slot-1];
                    slot--;
                end
                held_values[slot] = v;
                held_prios[slot]  = p;
                held++;
            end
        end else if (held == 0) begin
            r.status = spq_pkg::ST_EMPTY;
        end else begin
            r.status     = spq_pkg::ST_DEQ;
            r.head_value = held_values[0];
            for (int i = 1; i < held; i++) begin
                held_values[i-1] = held_values[i];
                held_prios[i-1]  = held_prios[i];
            end
            held--;
        end
        r.occupancy = spq_pkg::OCC_W'(held);
        return r;
    endfunction

    // replies are compared before the new transaction is predicted
    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            held = 0;
            awaited_replies.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    $display("%0t: reply with none awaited: status %0d head %0d occ %0d",
                             $time, m_status, m_head_value, m_occupancy);
                    faults++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_status);
                        faults++;
                    end
                    if (m_head_value !== want.head_value) begin
                        $display("%0t: head_value expected %0d actual %0d",
                                 $time, want.head_value, m_head_value);
                        faults++;
                    end
                    if (m_occupancy !== want.occupancy) begin
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $time, want.occupancy, m_occupancy);
                        faults++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                awaited_replies.push_back(apply_queue_op(s_kind, s_value, s_priority_req));
            end
        end
        mismatch_count      <= faults;
        replies_outstanding <= awaited_replies.size();
    end

endmodule

/* tb/tb_sorted_priority_queue.sv */
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

    logic                             aclk           = 1'b0;
    logic                             aresetn        = 1'b0;
    logic                             s_valid        = 1'b0;
    logic                             s_ready;
    logic                             s_kind         = spq_pkg::KIND_ENQ;
    logic signed [spq_pkg::VAL_W-1:0] s_value        = '0;
    logic [spq_pkg::PRI_W-1:0]        s_priority_req = '0;
    logic                             m_valid;
    logic                             m_ready        = 1'b0;
    logic [1:0]                       m_status;
    logic signed [spq_pkg::VAL_W-1:0] m_head_value;
    logic [spq_pkg::OCC_W-1:0]        m_occupancy;
    int                               mismatch_count;
    int                               replies_outstanding;
    bit                               steady         = 1'b0;

    sorted_priority_queue uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_value        (s_value),
        .s_priority_req (s_priority_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_head_value   (m_head_value),
        .m_occupancy    (m_occupancy)
    );

    spq_order_checker checker_i (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_kind              (s_kind),
        .s_value             (s_value),
        .s_priority_req      (s_priority_req),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_head_value        (m_head_value),
        .m_occupancy         (m_occupancy),
        .mismatch_count      (mismatch_count),
        .replies_outstanding (replies_outstanding)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // result side back-pressure, off during the steady stretch
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 33);
    end

    // present one transaction after a random gap and hold it until accepted
    task automatic send_op(input logic kind, input logic signed [spq_pkg::VAL_W-1:0] v,
                           input logic [spq_pkg::PRI_W-1:0] p);
        while (!steady && $urandom_range(99) < 33) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_value        <= v;
        s_priority_req <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin
        int                               phase_left;
        int                               enq_pct;
        logic                             kind;
        logic signed [spq_pkg::VAL_W-1:0] v;
        logic [spq_pkg::PRI_W-1:0]        p;
        phase_left = 0;
        enq_pct    = 50;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // dequeue from an empty queue
        send_op(spq_pkg::KIND_DEQ, 32'sh7FFF_FFFF, 8'hFF);
        // fill with extremes, ties at head, middle and tail
        send_op(spq_pkg::KIND_ENQ, 32'sh8000_0000, 8'hFF);
        send_op(spq_pkg::KIND_ENQ, 32'sh7FFF_FFFF, 8'h00);
        send_op(spq_pkg::KIND_ENQ, 32'sh0000_0000, 8'h80);
        send_op(spq_pkg::KIND_ENQ, -32'sd1,        8'h80);
        send_op(spq_pkg::KIND_ENQ, 32'sd1,         8'h80);
        send_op(spq_pkg::KIND_ENQ, 32'sd5,         8'h00);
        send_op(spq_pkg::KIND_ENQ, 32'sd6,         8'hFF);
        send_op(spq_pkg::KIND_ENQ, 32'sd7,         8'h40);
        // enqueue into a full queue
        send_op(spq_pkg::KIND_ENQ, 32'sh5555_5555, 8'h00);
        // drain everything, then one more dequeue on empty
        repeat (spq_pkg::DEPTH) send_op(spq_pkg::KIND_DEQ, 32'shAAAA_AAAA, 8'h55);
        send_op(spq_pkg::KIND_DEQ, 32'sd0, 8'h00);
        // alternate single entry in and out
        repeat (3) begin
            send_op(spq_pkg::KIND_ENQ, 32'sh1234_5678, 8'h11);
            send_op(spq_pkg::KIND_DEQ, 32'sh0, 8'h0);
        end

        // random phases that lean towards filling, draining or neither
        for (int n = 0; n < 1550; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(60, 10);
                case ($urandom_range(2))
                    0:       enq_pct = 80;
                    1:       enq_pct = 20;
                    default: enq_pct = 50;
                endcase
            end
            phase_left--;
            steady = (n >= 700 && n < 950);
            kind = ($urandom_range(99) < enq_pct) ? spq_pkg::KIND_ENQ : spq_pkg::KIND_DEQ;
            // narrow priorities often, so ties are common
            case ($urandom_range(9))
                0:          p = 8'h00;
                1:          p = 8'hFF;
                2, 3, 4, 5: p = spq_pkg::PRI_W'($urandom_range(3));
                default:    p = spq_pkg::PRI_W'($urandom);
            endcase
            v = $urandom;
            if ($urandom_range(19) == 0) begin
                v = $urandom_range(1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
            send_op(kind, v, p);
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        // drain outstanding replies, then allow for the output latency
        @(posedge aclk);
        while (replies_outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[sorted_priority_queue] OK");
        end else begin
            $display("[sorted_priority_queue] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("[sorted_priority_queue] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
tb/spq_order_checker.sv
tb/tb_sorted_priority_queue.sv
